// File: sv/ppe_pkg.sv
// ----------------------------------------------------------------------------
// ppe_pkg
// Widths, scale constants, sequencer states and meter constant selection
// for the pulse meter power and energy converter.
// ----------------------------------------------------------------------------
package ppe_pkg;

  // field widths
  localparam int CountW    = 16;
  localparam int IntervalW = 32;
  localparam int KW        = 16;
  localparam int PowerW    = 32;
  localparam int EnergyW   = 30;

  // datapath widths
  localparam int MulAW  = 16;
  localparam int MulBW  = 32;
  localparam int ProdW  = MulAW + MulBW;
  localparam int NumW   = 52;
  localparam int DenW   = 48;
  localparam int StepW  = 6;
  localparam int LeftW  = 16;

  // meter constant selection
  localparam logic [KW-1:0] KDefault    = 16'd5000;
  localparam logic [KW-1:0] KAltDefault = 16'hFFFF;

  // a single pulse is taken over one minute
  localparam logic [IntervalW-1:0] SinglePulseMs = 32'd60000;

  // 36000000000 = 17578125 * 2^11
  localparam logic [MulBW-1:0] PowerScaleOdd   = 32'd17578125;
  localparam int               PowerScaleShift = 11;
  localparam logic [MulBW-1:0] EnergyScale     = 32'd10000;

  // divider iteration counts, minus one
  localparam logic [StepW-1:0] PowerSteps  = 6'(NumW - 1);
  localparam logic [StepW-1:0] EnergySteps = 6'(EnergyW - 1);

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL_N = 7'b0000010,
    ST_MUL_D = 7'b0000100,
    ST_DIV_P = 7'b0001000,
    ST_MUL_E = 7'b0010000,
    ST_DIV_E = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  // zero and all-ones select the default meter constant
  function automatic logic [KW-1:0] eff_k(input logic [KW-1:0] k);
    logic [KW-1:0] r;
    r = k;
    if (k == '0 || k == KAltDefault) begin
      r = KDefault;
    end
    return r;
  endfunction

endpackage

// File: sv/ppe_sample_if.sv
// ----------------------------------------------------------------------------
// ppe_sample_if
// Input channel: pulse count and counting interval with valid/ready.
// ----------------------------------------------------------------------------
interface ppe_sample_if;
  logic                           valid;
  logic                           ready;
  logic [ppe_pkg::CountW-1:0]     pulse_count;
  logic [ppe_pkg::IntervalW-1:0]  interval_ms;

  modport source (output valid, pulse_count, interval_ms, input ready);
  modport sink   (input valid, pulse_count, interval_ms, output ready);
endinterface

// File: sv/ppe_result_if.sv
// ----------------------------------------------------------------------------
// ppe_result_if
// Output channel: power and energy increment with valid/ready.
// ----------------------------------------------------------------------------
interface ppe_result_if;
  logic                          valid;
  logic                          ready;
  logic [ppe_pkg::PowerW-1:0]    power;
  logic [ppe_pkg::EnergyW-1:0]   energy;

  modport source (output valid, power, energy, input ready);
  modport sink   (input valid, power, energy, output ready);
endinterface

// File: sv/pulse_power_energy_convert.sv
// ----------------------------------------------------------------------------
// pulse_power_energy_convert
// Sequence: two multiply steps, 52 power divide steps, one multiply step,
//   30 energy divide steps, then the result register once output is free.
// A new sample is taken only in idle, after the last result is registered;
//   shared restoring divider runs both divisions one quotient bit per cycle.
// Reset (rst, synchronous): sequencer idle, no result pending, meter
//   constant 0 (default 5000), energy leftover 0.
// ----------------------------------------------------------------------------
module pulse_power_energy_convert (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [ppe_pkg::KW-1:0]       cfg_wr_data,
  ppe_sample_if.sink                   sample,
  ppe_result_if.source                 result
);

  ppe_pkg::state_t state;

  logic [ppe_pkg::KW-1:0]        meter_k;
  logic [ppe_pkg::LeftW-1:0]     leftover;
  logic [ppe_pkg::CountW-1:0]    count_r;
  logic [ppe_pkg::IntervalW-1:0] interval_r;
  logic                          zero_pow;
  logic [ppe_pkg::NumW-1:0]      dvd;
  logic [ppe_pkg::DenW-1:0]      den;
  logic [ppe_pkg::DenW-1:0]      rem;
  logic [ppe_pkg::StepW-1:0]     step;
  logic [ppe_pkg::PowerW-1:0]    power_r;

  logic                          out_valid;
  logic [ppe_pkg::PowerW-1:0]    out_power;
  logic [ppe_pkg::EnergyW-1:0]   out_energy;

  logic [ppe_pkg::MulAW-1:0]     mul_a;
  logic [ppe_pkg::MulBW-1:0]     mul_b;
  logic [ppe_pkg::ProdW-1:0]     prod;

  logic [ppe_pkg::DenW:0]        trial;
  logic                          ge;
  logic [ppe_pkg::DenW-1:0]      rem_next;
  logic [ppe_pkg::EnergyW-1:0]   energy_total;
  logic                          in_fire;
  logic                          out_free;

  assign sample.ready  = (state == ppe_pkg::ST_IDLE);
  assign in_fire       = sample.valid && sample.ready;
  assign out_free      = !out_valid || result.ready;
  assign result.valid  = out_valid;
  assign result.power  = out_power;
  assign result.energy = out_energy;

  // shared multiplier operand select
  always_comb begin
    case (state)
      ppe_pkg::ST_MUL_N: begin
        mul_a = count_r;
        mul_b = ppe_pkg::PowerScaleOdd;
      end
      ppe_pkg::ST_MUL_D: begin
        mul_a = ppe_pkg::eff_k(meter_k);
        mul_b = interval_r;
      end
      default: begin
        mul_a = count_r;
        mul_b = ppe_pkg::EnergyScale;
      end
    endcase
  end

  assign prod = {{ppe_pkg::MulBW{1'b0}}, mul_a} * {{ppe_pkg::MulAW{1'b0}}, mul_b};

  // count * 10000 plus carried remainder
  assign energy_total = prod[ppe_pkg::EnergyW-1:0]
                      + {{(ppe_pkg::EnergyW - ppe_pkg::LeftW){1'b0}}, leftover};

  // one restoring divide step
  assign trial    = {rem, dvd[ppe_pkg::NumW-1]};
  assign ge       = (trial >= {1'b0, den});
  assign rem_next = ge ? ppe_pkg::DenW'(trial - {1'b0, den})
                       : trial[ppe_pkg::DenW-1:0];

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      meter_k <= '0;
    end else if (cfg_wr_en) begin
      meter_k <= cfg_wr_data;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ppe_pkg::ST_IDLE;
      leftover <= '0;
    end else begin
      case (state)
        ppe_pkg::ST_IDLE: begin
          if (in_fire) begin
            count_r    <= sample.pulse_count;
            interval_r <= (sample.pulse_count == ppe_pkg::CountW'(1))
                          ? ppe_pkg::SinglePulseMs : sample.interval_ms;
            state      <= ppe_pkg::ST_MUL_N;
          end
        end
        ppe_pkg::ST_MUL_N: begin
          // numerator = count * 36e9
          dvd   <= {prod[ppe_pkg::NumW-ppe_pkg::PowerScaleShift-1:0],
                    {ppe_pkg::PowerScaleShift{1'b0}}};
          rem   <= '0;
          state <= ppe_pkg::ST_MUL_D;
        end
        ppe_pkg::ST_MUL_D: begin
          den      <= prod;
          zero_pow <= (count_r == '0) || (interval_r == '0);
          step     <= ppe_pkg::PowerSteps;
          state    <= ppe_pkg::ST_DIV_P;
        end
        ppe_pkg::ST_DIV_P: begin
          rem  <= rem_next;
          dvd  <= {dvd[ppe_pkg::NumW-2:0], ge};
          step <= step - ppe_pkg::StepW'(1);
          if (step == '0) begin
            state <= ppe_pkg::ST_MUL_E;
          end
        end
        ppe_pkg::ST_MUL_E: begin
          // saturate power, then load the energy division
          if (zero_pow) begin
            power_r <= '0;
          end else if (|dvd[ppe_pkg::NumW-1:ppe_pkg::PowerW]) begin
            power_r <= '1;
          end else begin
            power_r <= dvd[ppe_pkg::PowerW-1:0];
          end
          dvd   <= {energy_total, {(ppe_pkg::NumW - ppe_pkg::EnergyW){1'b0}}};
          den   <= {{(ppe_pkg::DenW - ppe_pkg::KW){1'b0}}, ppe_pkg::eff_k(meter_k)};
          rem   <= '0;
          step  <= ppe_pkg::EnergySteps;
          state <= ppe_pkg::ST_DIV_E;
        end
        ppe_pkg::ST_DIV_E: begin
          rem  <= rem_next;
          dvd  <= {dvd[ppe_pkg::NumW-2:0], ge};
          step <= step - ppe_pkg::StepW'(1);
          if (step == '0) begin
            state <= ppe_pkg::ST_DONE;
          end
        end
        ppe_pkg::ST_DONE: begin
          if (out_free) begin
            leftover <= rem[ppe_pkg::LeftW-1:0];
            state    <= ppe_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= ppe_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ppe_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ppe_pkg::ST_DONE && out_free) begin
      out_power  <= power_r;
      out_energy <= dvd[ppe_pkg::EnergyW-1:0];
    end
  end

endmodule

// File: tb/sv/pulse_power_energy_convert_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_power_energy_convert_tb
// Self-checking bench for the pulse meter converter. Directed and random
// pulse samples are sent under several meter constants, including the
// smallest, largest and both default codes. A scoreboard predicts power and
// energy per sample, carries the energy remainder, and compares each result
// transaction in order. Both channels see random gaps, and one long output
// stall backs the converter up.
// ----------------------------------------------------------------------------
module pulse_power_energy_convert_tb;

  localparam int          CycleLimit   = 2_000_000;
  localparam int          HoldCycles   = 600;
  localparam int          HoldAfterIn  = 40;
  localparam int          RandPerPhase = 110;
  localparam int          RandPhases   = 8;
  localparam logic [63:0] PowerScale   = 64'd36000000000;
  localparam logic [63:0] EnergyUnits  = 64'd10000;
  localparam logic [63:0] PowerMax     = 64'h0000_0000_FFFF_FFFF;

  // one expected reading
  typedef struct {
    logic [ppe_pkg::PowerW-1:0]  power;
    logic [ppe_pkg::EnergyW-1:0] energy;
  } meter_reading_t;

  // expected readings plus a private copy of meter constant and remainder
  class energy_scoreboard;
    meter_reading_t         readings_due[$];
    logic [ppe_pkg::KW-1:0] meter_k;
    logic [15:0]            leftover;
    int                     n_in;
    int                     n_out;
    int                     n_bad;

    function new();
      meter_k  = '0;
      leftover = '0;
      n_in     = 0;
      n_out    = 0;
      n_bad    = 0;
    endfunction

    function void set_k(logic [ppe_pkg::KW-1:0] k);
      meter_k = k;
    endfunction

    function int pending();
      return readings_due.size();
    endfunction

    // work out power and energy for an accepted sample
    function void predict_reading(logic [ppe_pkg::CountW-1:0] cnt,
                                  logic [ppe_pkg::IntervalW-1:0] ivl);
      logic [63:0]    k;
      logic [63:0]    c;
      logic [63:0]    t;
      logic [63:0]    pw;
      logic [63:0]    total;
      meter_reading_t r;
      k  = 64'(meter_k);
      if (meter_k == '0 || meter_k == ppe_pkg::KAltDefault) begin
        k = 64'(ppe_pkg::KDefault);
      end
      c  = 64'(cnt);
      t  = 64'(ivl);
      pw = '0;
      if (c != 0) begin
        // a single pulse is spread over one minute
        if (c == 1) begin
          t = 64'(ppe_pkg::SinglePulseMs);
        end
        if (t != 0) begin
          pw = (PowerScale * c) / (k * t);
          if (pw > PowerMax) begin
            pw = PowerMax;
          end
        end
      end
      // energy carries the division remainder into the next sample
      total    = c * EnergyUnits + 64'(leftover);
      r.power  = pw[31:0];
      r.energy = 30'(total / k);
      leftover = 16'(total % k);
      readings_due.push_back(r);
      n_in++;
    endfunction

    // compare a result transaction with the oldest expectation
    function void check_reading(logic [ppe_pkg::PowerW-1:0] pw,
                                logic [ppe_pkg::EnergyW-1:0] en);
      meter_reading_t r;
      n_out++;
      if (readings_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("unexpected result: power=%0d energy=%0d", pw, en);
        end
        return;
      end
      r = readings_due.pop_front();
      if (pw !== r.power || en !== r.energy) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("mismatch on result %0d: power exp %0d got %0d, energy exp %0d got %0d",
                   n_out, r.power, pw, r.energy, en);
        end
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         cfg_wr_en;
  logic [ppe_pkg::KW-1:0]       cfg_wr_data;
  bit                           gaps_on;
  bit                           hold_done;
  int                           n_settings;
  int                           cycles;
  logic [ppe_pkg::KW-1:0]       phase_k [RandPhases];
  energy_scoreboard             sb = new();

  ppe_sample_if sample_bus ();
  ppe_result_if result_bus ();

  pulse_power_energy_convert uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sample      (sample_bus),
    .result      (result_bus)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (!gaps_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 20);
    return $urandom_range(30, 150);
  endfunction

  // offer one sample and wait until it is taken
  task automatic send_sample(input logic [ppe_pkg::CountW-1:0] cnt,
                             input logic [ppe_pkg::IntervalW-1:0] ivl);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_bus.valid       <= 1'b1;
    sample_bus.pulse_count <= cnt;
    sample_bus.interval_ms <= ivl;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
  endtask

  // random sample, weighted toward the special counts and intervals
  task automatic send_random();
    logic [ppe_pkg::CountW-1:0]    cnt;
    logic [ppe_pkg::IntervalW-1:0] ivl;
    int                            r;
    r = $urandom_range(0, 99);
    if (r < 10)      cnt = '0;
    else if (r < 20) cnt = 16'd1;
    else if (r < 28) cnt = 16'($urandom_range(65500, 65535));
    else if (r < 55) cnt = 16'($urandom_range(2, 200));
    else             cnt = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (r < 8)       ivl = '0;
    else if (r < 20) ivl = 32'($urandom_range(1, 16));
    else if (r < 50) ivl = 32'($urandom_range(1000, 120000));
    else             ivl = $urandom;
    send_sample(cnt, ivl);
  endtask

  // stop offering, then wait for every expected reading plus a margin
  task automatic wait_idle(input int settle);
    sample_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // meter constant write, only while the converter is idle
  task automatic write_k(input logic [ppe_pkg::KW-1:0] k);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_k(k);
    n_settings++;
    @(posedge clk);
  endtask

  // cycle count and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d readings outstanding", cycles, sb.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // note accepted sample transactions
  always @(posedge clk) begin
    if (!rst && sample_bus.valid && sample_bus.ready) begin
      sb.predict_reading(sample_bus.pulse_count, sample_bus.interval_ms);
    end
  end

  // check accepted result transactions
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      sb.check_reading(result_bus.power, result_bus.energy);
    end
  end

  // result receiver with random stalls and one long hold-off
  initial begin
    int gap;
    result_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && sb.n_in >= HoldAfterIn) begin
        hold_done = 1'b1;
        result_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      gap = pick_gap();
      if (gap > 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      @(posedge clk);
      while (!result_bus.valid) @(posedge clk);
    end
  end

  // stimulus
  initial begin
    cycles                 = 0;
    n_settings             = 0;
    hold_done              = 1'b0;
    gaps_on                = 1'b1;
    rst                    <= 1'b1;
    cfg_wr_en              <= 1'b0;
    cfg_wr_data            <= '0;
    sample_bus.valid       <= 1'b0;
    sample_bus.pulse_count <= '0;
    sample_bus.interval_ms <= '0;
    phase_k[0] = 16'd1;
    phase_k[1] = 16'hFFFE;
    phase_k[2] = 16'd0;
    phase_k[3] = 16'hFFFF;
    phase_k[4] = 16'd2;
    phase_k[5] = 16'($urandom_range(3, 65533));
    phase_k[6] = 16'd3600;
    phase_k[7] = 16'($urandom_range(0, 65535));
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset meter constant selects the default
    send_sample(16'd0, 32'd0);
    send_sample(16'd0, 32'd1000);
    send_sample(16'd1, 32'd0);
    send_sample(16'd1, 32'hFFFF_FFFF);
    send_sample(16'd2, 32'd0);
    send_sample(16'hFFFF, 32'd1);
    send_sample(16'hFFFF, 32'hFFFF_FFFF);
    send_sample(16'd1000, 32'd60000);
    send_sample(16'd3, 32'd1);
    send_sample(16'hAAAA, 32'h5555_5555);
    send_sample(16'h5555, 32'hAAAA_AAAA);
    wait_idle(4);

    // largest constant builds a big remainder
    write_k(16'hFFFE);
    send_sample(16'hFFFF, 32'd7);
    send_sample(16'd1, 32'd1);
    send_sample(16'hFFFF, 32'hFFFF_FFFF);
    wait_idle(4);

    // smallest constant: old remainder paid out on a zero count, saturation
    write_k(16'd1);
    send_sample(16'd0, 32'd0);
    send_sample(16'hFFFF, 32'd1);
    send_sample(16'd1, 32'd60000);
    wait_idle(4);

    // both default codes written explicitly
    write_k(16'hFFFF);
    send_sample(16'd7, 32'd123456);
    wait_idle(4);
    write_k(16'd0);
    send_sample(16'd12, 32'd0);
    wait_idle(4);

    // random phases, one of them with no idling at all
    for (int ph = 0; ph < RandPhases; ph++) begin
      gaps_on = (ph != 3);
      write_k(phase_k[ph]);
      repeat (RandPerPhase) send_random();
      wait_idle(4);
    end
    gaps_on = 1'b1;

    wait_idle(100);
    $display("sent %0d samples and checked %0d readings over %0d meter constant settings",
             sb.n_in, sb.n_out, n_settings);
    $display("long output hold-off %0s, mismatches %0d",
             hold_done ? "done" : "missed", sb.n_bad);
    if (sb.n_bad == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
